// ===== design/mexp_pkg.sv =====
package mexp_pkg;

   // Width of the payload and configuration data ports.
   localparam int FIELD_BITS = 32;

   // Default operand width of the arithmetic.
   localparam int WORD_BITS_DEFAULT = 32;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODULUS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXPONENT = 2'd1;

endpackage

// ===== design/mexp_modmul.sv =====
module mexp_modmul #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   input  logic [WORD_BITS-1:0] modulus,
   output logic                 done,
   output logic [WORD_BITS-1:0] product
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(WORD_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] mult_ff, mult_in;
   logic [WORD_BITS-1:0] mcand_ff, mcand_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;

   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS:0]   sum_red;
   logic [WORD_BITS:0]   dbl;
   logic [WORD_BITS:0]   dbl_red;
   logic [WORD_BITS:0]   modulus_ext;

   // One bit of the multiplier a step, least significant first. The running
   // sum takes the current multiple of op_b, which doubles every step; both
   // stay below the modulus, so one conditional subtraction reduces each.
   always_comb begin
      modulus_ext = {1'b0, modulus};
      addend      = mult_ff[0] ? mcand_ff : '0;
      sum         = {1'b0, acc_ff} + {1'b0, addend};
      sum_red     = sum - modulus_ext;
      dbl         = {mcand_ff, 1'b0};
      dbl_red     = dbl - modulus_ext;
   end

   // Step sequencing.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mult_in  = mult_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mult_in  = op_a;
         mcand_in = op_b;
         acc_in   = '0;
      end else if (busy_ff) begin
         mult_in  = mult_ff >> 1;
         acc_in   = (sum >= modulus_ext) ? sum_red[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
         mcand_in = (dbl >= modulus_ext) ? dbl_red[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      mult_ff  <= mult_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== design/mexp_ctrl.sv =====
module mexp_ctrl #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] base,
   input  logic [WORD_BITS-1:0] modulus,
   input  logic [WORD_BITS-1:0] exponent,
   output logic                 busy,
   output logic                 result_valid,
   output logic [WORD_BITS-1:0] result,
   output logic                 mul_start,
   output logic [WORD_BITS-1:0] mul_a,
   output logic [WORD_BITS-1:0] mul_b,
   input  logic                 mul_done,
   input  logic [WORD_BITS-1:0] mul_product
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_STEP   = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_SQUARE = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic                 valid_ff, valid_in;
   logic [WORD_BITS-1:0] result_ff, result_in;
   logic [WORD_BITS-1:0] pow_ff, pow_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;

   logic [WORD_BITS-1:0] one_mod;
   logic [WORD_BITS-1:0] exp_rest;

   // Sequencer: reduce the base, then scan the exponent from its least
   // significant bit, multiplying on a set bit and squaring after each bit but the highest set one.
   always_comb begin
      state_in  = state_ff;
      valid_in  = 1'b0;
      result_in = result_ff;
      pow_in    = pow_ff;
      acc_in    = acc_ff;
      exp_in    = exp_ff;
      mul_start = 1'b0;
      mul_a     = acc_ff;
      mul_b     = pow_ff;
      one_mod   = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
      exp_rest  = exp_ff >> 1;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               exp_in = exponent;
               acc_in = WORD_BITS'(1);
               if (exponent == '0) begin
                  // A zero exponent gives one, left unreduced.
                  valid_in  = 1'b1;
                  result_in = WORD_BITS'(1);
               end else begin
                  // The base times one modulo n is the reduced base.
                  mul_start = 1'b1;
                  mul_a     = base;
                  mul_b     = one_mod;
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               pow_in   = mul_product;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            mul_start = 1'b1;
            if (exp_ff[0]) begin
               mul_a    = acc_ff;
               mul_b    = pow_ff;
               state_in = ST_MULT;
            end else begin
               mul_a    = pow_ff;
               mul_b    = pow_ff;
               exp_in   = exp_rest;
               state_in = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               acc_in = mul_product;
               exp_in = exp_rest;
               if (exp_rest == '0) begin
                  // Highest set bit done: no further square is needed.
                  valid_in  = 1'b1;
                  result_in = mul_product;
                  state_in  = ST_IDLE;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = pow_ff;
                  mul_b     = pow_ff;
                  state_in  = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               pow_in   = mul_product;
               state_in = ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      pow_ff    <= pow_in;
      acc_ff    <= acc_in;
      exp_ff    <= exp_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign result_valid = valid_ff;
   assign result       = result_ff;

endmodule

// ===== design/modular_exponentiation.sv =====
// Channel   Ports                                          Direction
// request   start, busy, req_base_value                    in (busy out)
// response  rsp_valid, rsp_power_result                    out
// config    csr_write_enable, csr_index, csr_write_data    in
//
// A beat is taken when start is high and busy is low. With a zero exponent
// the result beat follows in the cycle after the request. Otherwise the
// time to the result is set by the shared bit-serial modular multiplier,
// which forms each product one multiplier bit at a step. busy stays high
// until the result cycle.
// Reset is synchronous and clears the sequencer; modulus returns to 1 and
// exponent to 0. The receiver cannot stall: each result shows for one cycle.
module modular_exponentiation #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [mexp_pkg::FIELD_BITS-1:0]       req_base_value,
   output logic                                  rsp_valid,
   output logic [mexp_pkg::FIELD_BITS-1:0]       rsp_power_result,
   input  logic                                  csr_write_enable,
   input  logic [mexp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mexp_pkg::FIELD_BITS-1:0]       csr_write_data
);

   import mexp_pkg::*;

   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] exponent_ff, exponent_in;
   logic [WORD_BITS-1:0] write_word;

   logic                 mul_start;
   logic [WORD_BITS-1:0] mul_a;
   logic [WORD_BITS-1:0] mul_b;
   logic                 mul_done;
   logic [WORD_BITS-1:0] mul_product;
   logic [WORD_BITS-1:0] result;

   // Configuration registers; a write of a zero modulus is dropped.
   always_comb begin
      write_word  = csr_write_data[WORD_BITS-1:0];
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_MODULUS: begin
               if (write_word != '0) begin
                  modulus_in = write_word;
               end
            end
            REG_EXPONENT: begin
               exponent_in = write_word;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= WORD_BITS'(1);
         exponent_ff <= '0;
      end else begin
         modulus_ff  <= modulus_in;
         exponent_ff <= exponent_in;
      end
   end

   // Sequencer.
   mexp_ctrl #(
      .WORD_BITS(WORD_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .base         (req_base_value[WORD_BITS-1:0]),
      .modulus      (modulus_ff),
      .exponent     (exponent_ff),
      .busy         (busy),
      .result_valid (rsp_valid),
      .result       (result),
      .mul_start    (mul_start),
      .mul_a        (mul_a),
      .mul_b        (mul_b),
      .mul_done     (mul_done),
      .mul_product  (mul_product)
   );

   // Shared modular multiplier.
   mexp_modmul #(
      .WORD_BITS(WORD_BITS)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   assign rsp_power_result = FIELD_BITS'(result);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import mexp_pkg::*;

   localparam int W            = 32;
   localparam int RANDOM_BEATS = 274;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_LIMIT  = 10000;
   localparam int DIRECTED_ROWS = 30;

   // Indexes past the end of the register map; writes there must do nothing.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

   typedef enum logic {ROW_CSR, ROW_BASE} row_kind_type;

   // One row of the directed table: either a register write or a base beat,
   // the latter optionally with a result that is obvious by inspection.
   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [FIELD_BITS-1:0]     value;
      bit                        known;
      logic [FIELD_BITS-1:0]     result;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [FIELD_BITS-1:0]     req_base_value = '0;
   logic                      rsp_valid;
   logic [FIELD_BITS-1:0]     rsp_power_result;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_MODULUS;
   logic [FIELD_BITS-1:0]     csr_write_data = '0;

   // Shadow copies of the registers, as the block should hold them.
   logic [FIELD_BITS-1:0] shadow_modulus  = 32'd1;
   logic [FIELD_BITS-1:0] shadow_exponent = 32'd0;

   // Powers still owed by the block, oldest first.
   logic [FIELD_BITS-1:0] pending_powers[$];

   int fail_count     = 0;
   int results_seen   = 0;
   int beats_sent     = 0;
   int csr_writes     = 0;
   int mid_run_drains = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // Straight after reset: exponent zero gives 1 whatever the base.
      '{ROW_BASE, REG_MODULUS,  32'h0000_0000, 1'b1, 32'h0000_0001},
      '{ROW_BASE, REG_MODULUS,  32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
      // Modulus one with a nonzero exponent gives 0.
      '{ROW_CSR,  REG_EXPONENT, 32'h0000_0005, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0007, 1'b1, 32'h0000_0000},
      // A zero modulus write is dropped, so the modulus stays one.
      '{ROW_CSR,  REG_MODULUS,  32'h0000_0000, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0009, 1'b1, 32'h0000_0000},
      // Widest modulus and exponent.
      '{ROW_CSR,  REG_MODULUS,  32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_CSR,  REG_EXPONENT, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0001, 1'b1, 32'h0000_0001},
      '{ROW_BASE, REG_MODULUS,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{ROW_BASE, REG_MODULUS,  32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
      '{ROW_BASE, REG_MODULUS,  32'h1234_5678, 1'b0, 32'h0},
      // Exponent zero is not reduced.
      '{ROW_CSR,  REG_EXPONENT, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'hDEAD_BEEF, 1'b1, 32'h0000_0001},
      // Smallest useful modulus and exponent.
      '{ROW_CSR,  REG_MODULUS,  32'h0000_0002, 1'b0, 32'h0},
      '{ROW_CSR,  REG_EXPONENT, 32'h0000_0001, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0003, 1'b1, 32'h0000_0001},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0004, 1'b1, 32'h0000_0000},
      // Writes beyond the register map must leave both registers alone.
      '{ROW_CSR,  REG_SPARE_LO, 32'h0000_0055, 1'b0, 32'h0},
      '{ROW_CSR,  REG_SPARE_HI, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0006, 1'b1, 32'h0000_0000},
      // Largest 32-bit prime with only the top exponent bit set.
      '{ROW_CSR,  REG_MODULUS,  32'hFFFF_FFFB, 1'b0, 32'h0},
      '{ROW_CSR,  REG_EXPONENT, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'h0000_0002, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'hFFFF_FFFA, 1'b1, 32'h0000_0001},
      // The usual public exponent; the last base reduces to one.
      '{ROW_CSR,  REG_EXPONENT, 32'h0001_0001, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'hAAAA_AAAA, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'h5555_5555, 1'b0, 32'h0},
      '{ROW_BASE, REG_MODULUS,  32'hFFFF_FFFC, 1'b1, 32'h0000_0001}
   };

   modular_exponentiation #(
      .WORD_BITS(W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_base_value   (req_base_value),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Right-to-left square and multiply with 64-bit products.
   function automatic logic [FIELD_BITS-1:0] predict_power(
      input logic [FIELD_BITS-1:0] base,
      input logic [FIELD_BITS-1:0] expo,
      input logic [FIELD_BITS-1:0] modu
   );
      logic [63:0]           acc;
      logic [63:0]           sq;
      logic [63:0]           n;
      logic [FIELD_BITS-1:0] bits;
      acc  = 64'd1;
      n    = {32'd0, modu};
      sq   = {32'd0, base} % n;
      bits = expo;
      for (int k = 0; k < W; k++) begin
         if (bits[0]) begin
            acc = (acc * sq) % n;
         end
         bits = bits >> 1;
         sq   = (sq * sq) % n;
      end
      return acc[FIELD_BITS-1:0];
   endfunction

   task automatic report_miscompare(input string what, input logic [FIELD_BITS-1:0] want,
                                    input logic [FIELD_BITS-1:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: %s: wanted %h, got %h", $realtime, what, want, got);
      end
   endtask

   // Each result beat is compared with the oldest outstanding power.
   always @(posedge clock) begin
      logic [FIELD_BITS-1:0] want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_powers.size() == 0) begin
            report_miscompare("result beat with nothing outstanding", '0, rsp_power_result);
         end else begin
            want = pending_powers.pop_front();
            if (rsp_power_result !== want) begin
               report_miscompare("power_result mismatch", want, rsp_power_result);
            end
         end
      end
   end

   // Register write; the enable is low again before the task returns, which keeps the enable edges apart.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [FIELD_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == REG_MODULUS) begin
         if (data != '0) begin
            shadow_modulus = data;
         end
      end else if (index == REG_EXPONENT) begin
         shadow_exponent = data;
      end
      csr_writes++;
      @(posedge clock);
   endtask

   // Holds start high until the block takes the beat, then books the power.
   task automatic send_base(input logic [FIELD_BITS-1:0] base, input bit known,
                            input logic [FIELD_BITS-1:0] fixed_result);
      start          <= 1'b1;
      req_base_value <= base;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (known) begin
         pending_powers.push_back(fixed_result);
      end else begin
         pending_powers.push_back(predict_power(base, shadow_exponent, shadow_modulus));
      end
      beats_sent++;
   endtask

   // Stops sending and waits until every owed result has come back, or until DRAIN_LIMIT runs out.
   task automatic wait_for_drain();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while ((pending_powers.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   initial begin
      logic [FIELD_BITS-1:0] pick;
      int random_beats;
      int phase_len;
      int phases;
      int directed_beats;
      bit quiet;
      random_beats   = 0;
      phases         = 0;
      directed_beats = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_for_drain();
            write_csr(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_base(directed_rows[r].value, directed_rows[r].known, directed_rows[r].result);
            directed_beats++;
         end
      end

      // Random phases, each with fresh register settings.
      while (random_beats < RANDOM_BEATS) begin
         wait_for_drain();
         phases++;
         case ($urandom_range(0, 5))
            0:       pick = 32'd1;
            1:       pick = 32'hFFFF_FFFF;
            2:       pick = $urandom_range(2, 255);
            default: pick = $urandom;
         endcase
         write_csr(REG_MODULUS, pick);
         case ($urandom_range(0, 5))
            0:       pick = 32'd0;
            1:       pick = 32'hFFFF_FFFF;
            2:       pick = $urandom_range(1, 15);
            default: pick = $urandom;
         endcase
         write_csr(REG_EXPONENT, pick);
         // Now and then a write that must be ignored.
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0:       write_csr(REG_MODULUS, '0);
               1:       write_csr(REG_SPARE_LO, $urandom);
               default: write_csr(REG_SPARE_HI, $urandom);
            endcase
         end

         // A phase is stretched so that the quiet stretch is never cut by new settings.
         phase_len = $urandom_range(15, 35);
         for (int i = 0; (i < phase_len || (random_beats >= 120 && random_beats < 180))
                         && random_beats < RANDOM_BEATS; i++) begin
            case ($urandom_range(0, 9))
               0:       pick = 32'd0;
               1:       pick = 32'hFFFF_FFFF;
               2:       pick = shadow_modulus - 32'd1;
               3:       pick = shadow_modulus;
               4:       pick = $urandom_range(0, 3);
               default: pick = $urandom;
            endcase
            send_base(pick, 1'b0, '0);
            random_beats++;

            // Sender gaps, except over one long quiet stretch.
            quiet = (random_beats >= 120 && random_beats < 180);
            if (random_beats == 60 || (!quiet && $urandom_range(0, 39) == 0)) begin
               wait_for_drain();
               mid_run_drains++;
            end else if (!quiet && $urandom_range(0, 99) < 12) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 40)) @(posedge clock);
            end
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      while (pending_powers.size() != 0) begin
         report_miscompare("result never arrived", pending_powers.pop_front(), '0);
      end

      $display("Sent %0d base beats (%0d directed, %0d random over %0d settings phases).",
               beats_sent, directed_beats, random_beats, phases);
      $display("Checked %0d results; %0d register writes, %0d mid-run drains, %0d failures.",
               results_seen, csr_writes, mid_run_drains, fail_count);
      if (fail_count == 0) begin
         $display("[modular_exponentiation] OK");
      end else begin
         $display("[modular_exponentiation] ERROR");
      end
      $finish;
   end

   // Guard against a hung block.
   initial begin
      #15_000_000;
      $display("Timed out with %0d results outstanding.", pending_powers.size());
      $display("[modular_exponentiation] ERROR");
      $finish;
   end

endmodule
